### sv/lrup_pkg.sv
package lrup_pkg;

  // fixed field widths of the page reference and result words
  localparam int PAGE_W      = 4;
  localparam int FRAME_IDX_W = 3;
  localparam int TOTAL_W     = 32;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EVICT
  } lrup_state_t;

  // outcome of one lookup; a miss with neither flag set fills an empty frame
  typedef struct packed {
    logic hit;
    logic evict;
  } lrup_dec_t;

endpackage

### sv/lru_page_replacement.sv
// LRU page replacement table.
// Request channel: req_valid / req_stall carry one page reference word (page).
// A word is taken on a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall carry one result word per request:
// fault, frame_index, evicted_valid, evicted_page and the saturating fault_total.
// The user must write frame_count (cfg_wr_en / cfg_wr_data) only while idle;
// the block does not enforce this. A hit or a fill into an empty frame is
// decided in ST_LOOK, which registers its result once the output register is
// free and returns to ST_IDLE, where the next request is taken; an eviction
// passes through ST_EVICT as well for the second write to the page-to-frame
// bitmask memory, which is indexed by page and has a single write port; lookups
// read one bitmask word per request. After reset the bitmask memory is cleared,
// one page entry a cycle, while req_stall is high; configuration writes are
// taken then. The result sits in an output register; while rsp_stall holds it,
// the block still takes the next request but keeps that request's result until
// the output register frees up.
module lru_page_replacement #(
  parameter int FRAMES = 8,
  parameter int PAGES  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [lrup_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [lrup_pkg::PAGE_W-1:0]        page,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               fault,
  output logic [lrup_pkg::FRAME_IDX_W-1:0]   frame_index,
  output logic                               evicted_valid,
  output logic [lrup_pkg::PAGE_W-1:0]        evicted_page,
  output logic [lrup_pkg::TOTAL_W-1:0]       fault_total
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int PW = $clog2(PAGES);
  localparam int VW = 9;

  lrup_pkg::lrup_state_t state, state_next;

  logic [lrup_pkg::CFG_W-1:0]   frame_count;
  logic [lrup_pkg::PAGE_W-1:0]  pg;
  logic [PW-1:0]                clr_addr;
  logic [FW-1:0]                res_frame;
  logic [lrup_pkg::TOTAL_W-1:0] fault_counter;
  logic [lrup_pkg::TOTAL_W-1:0] fault_inc;

  logic                         accept;
  logic                         out_free;
  logic                         look_commit;
  logic [VW-1:0]                pg_red;
  logic [CW-1:0]                n_act;
  logic [FRAMES-1:0]            active;
  logic [FRAMES-1:0]            frame_onehot;
  logic [FRAMES-1:0]            res_onehot;

  logic                         mask_we;
  logic [PW-1:0]                mask_waddr;
  logic [FRAMES-1:0]            mask_wmask;
  logic [FRAMES-1:0]            mask_wdata;
  logic [FRAMES-1:0]            mask_rdata;
  logic                         pmem_we;
  logic                         pmem_re;
  logic [lrup_pkg::PAGE_W-1:0]  pmem_rdata;

  lrup_pkg::lrup_dec_t          dec;
  logic [FW-1:0]                frame;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // fold the page number into the table's page range
  always_comb begin
    pg_red = VW'(page);
    for (int i = 0; i < 8; i++) begin
      if (pg_red >= VW'(PAGES)) begin
        pg_red = pg_red - VW'(PAGES);
      end
    end
  end

  always_comb begin
    if (frame_count == '0) begin
      n_act = CW'(1);
    end else if (32'(frame_count) > 32'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(frame_count);
    end
    for (int k = 0; k < FRAMES; k++) begin
      active[k] = CW'(k) < n_act;
    end
  end

  always_comb begin
    frame_onehot        = '0;
    frame_onehot[frame] = 1'b1;
    res_onehot            = '0;
    res_onehot[res_frame] = 1'b1;
  end

  assign fault_inc = (fault_counter == '1) ? fault_counter
                                           : fault_counter + lrup_pkg::TOTAL_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrup_pkg::ST_CLEAR: begin
        if (clr_addr == PW'(PAGES - 1)) begin
          state_next = lrup_pkg::ST_IDLE;
        end
      end
      lrup_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lrup_pkg::ST_LOOK;
        end
      end
      lrup_pkg::ST_LOOK: begin
        if (dec.evict) begin
          state_next = lrup_pkg::ST_EVICT;
        end else if (out_free) begin
          state_next = lrup_pkg::ST_IDLE;
        end
      end
      lrup_pkg::ST_EVICT: begin
        if (out_free) begin
          state_next = lrup_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrup_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    req_stall   = 1'b1;
    look_commit = 1'b0;
    mask_we     = 1'b0;
    mask_waddr  = PW'(pg);
    mask_wmask  = '0;
    mask_wdata  = '0;
    pmem_we     = 1'b0;
    pmem_re     = 1'b0;
    case (state)
      lrup_pkg::ST_CLEAR: begin
        mask_we    = 1'b1;
        mask_waddr = clr_addr;
        mask_wmask = '1;
      end
      lrup_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      lrup_pkg::ST_LOOK: begin
        // an eviction commits now and waits for the output in the next state
        look_commit = dec.evict || out_free;
        if (look_commit && !dec.hit) begin
          mask_we    = 1'b1;
          mask_waddr = PW'(pg);
          mask_wmask = frame_onehot;
          mask_wdata = '1;
          pmem_we    = 1'b1;
          pmem_re    = dec.evict;
        end
      end
      lrup_pkg::ST_EVICT: begin
        if (out_free) begin
          mask_we    = 1'b1;
          mask_waddr = PW'(pmem_rdata);
          mask_wmask = res_onehot;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  lrup_ram #(
    .DEPTH (PAGES),
    .WIDTH (FRAMES)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wmask (mask_wmask),
    .wdata (mask_wdata),
    .re    (accept),
    .raddr (PW'(pg_red)),
    .rdata (mask_rdata)
  );

  lrup_ram #(
    .DEPTH (FRAMES),
    .WIDTH (lrup_pkg::PAGE_W)
  ) u_page_ram (
    .clk   (clk),
    .we    (pmem_we),
    .waddr (frame),
    .wmask ('1),
    .wdata (pg),
    .re    (pmem_re),
    .raddr (frame),
    .rdata (pmem_rdata)
  );

  lrup_rank #(
    .FRAMES (FRAMES)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .mask   (mask_rdata),
    .active (active),
    .commit (look_commit),
    .dec    (dec),
    .frame  (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lrup_pkg::ST_CLEAR;
      clr_addr      <= '0;
      frame_count   <= lrup_pkg::FRAME_COUNT_RESET;
      fault_counter <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lrup_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + PW'(1);
      end
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      if (look_commit && !dec.hit) begin
        fault_counter <= fault_inc;
      end
      if (state == lrup_pkg::ST_LOOK && !dec.evict && out_free) begin
        rsp_valid <= 1'b1;
      end else if (state == lrup_pkg::ST_EVICT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload: hold the request page and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      pg <= lrup_pkg::PAGE_W'(pg_red);
    end
    if (look_commit) begin
      res_frame <= frame;
    end
    if (state == lrup_pkg::ST_LOOK && !dec.evict && out_free) begin
      fault         <= !dec.hit;
      frame_index   <= lrup_pkg::FRAME_IDX_W'(frame);
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      fault_total   <= dec.hit ? fault_counter : fault_inc;
    end
    if (state == lrup_pkg::ST_EVICT && out_free) begin
      fault         <= 1'b1;
      frame_index   <= lrup_pkg::FRAME_IDX_W'(res_frame);
      evicted_valid <= 1'b1;
      evicted_page  <= pmem_rdata;
      fault_total   <= fault_counter;
    end
  end

endmodule

### sv/lrup_ram.sv
module lrup_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wmask,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // bit-masked write; a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lrup_rank.sv
module lrup_rank #(
  parameter int FRAMES = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [FRAMES-1:0]                           mask,
  input  logic [FRAMES-1:0]                           active,
  input  logic                                        commit,
  output lrup_pkg::lrup_dec_t                         dec,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [FRAMES-1:0] used;
  logic [FW-1:0]     rank [FRAMES];

  logic [FRAMES-1:0] hits;
  logic [FRAMES-1:0] empties;
  logic [FRAMES-1:0] is_min;
  logic [FW-1:0]     hit_idx;
  logic [FW-1:0]     emp_idx;
  logic [FW-1:0]     vic_idx;
  logic [CW-1:0]     used_cnt;
  logic [FW-1:0]     sel_rank;
  logic [FW-1:0]     top_rank;

  assign hits    = mask & used & active;
  assign empties = ~used & active;

  // lowest-numbered hit and lowest-numbered empty frame
  always_comb begin
    hit_idx = '0;
    emp_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (hits[k]) begin
        hit_idx = FW'(k);
      end
      if (empties[k]) begin
        emp_idx = FW'(k);
      end
    end
  end

  // ranks of used frames are distinct, so when all active frames are used exactly one is lowest
  always_comb begin
    is_min = active;
    for (int k = 0; k < FRAMES; k++) begin
      for (int j = 0; j < FRAMES; j++) begin
        if (j != k && active[j] && rank[j] < rank[k]) begin
          is_min[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    vic_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (is_min[k]) begin
        vic_idx = FW'(k);
      end
    end
  end

  always_comb begin
    used_cnt = '0;
    for (int k = 0; k < FRAMES; k++) begin
      used_cnt = used_cnt + CW'(used[k]);
    end
  end

  always_comb begin
    dec.hit   = |hits;
    dec.evict = !(|hits) && !(|empties);
    if (dec.hit) begin
      frame = hit_idx;
    end else if (!dec.evict) begin
      frame = emp_idx;
    end else begin
      frame = vic_idx;
    end
  end

  assign sel_rank = rank[frame];
  assign top_rank = FW'(used_cnt - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        rank[k] <= '0;
      end
    end else if (commit) begin
      if (!dec.hit && !dec.evict) begin
        // fill: the new frame goes on top of the current used set
        used[frame] <= 1'b1;
        rank[frame] <= FW'(used_cnt);
      end else begin
        // promote: close the gap above the old rank, move frame to the top
        for (int k = 0; k < FRAMES; k++) begin
          if (used[k] && rank[k] > sel_rank) begin
            rank[k] <= rank[k] - FW'(1);
          end
        end
        rank[frame] <= top_rank;
      end
    end
  end

endmodule
